// ----- design/hkwd_pkg.sv -----
// Shared types, constants and mixing helpers for the keystream weight decryptor.
package hkwd_pkg;

    localparam int DATA_W     = 32;
    localparam int LAYER_W    = 16;
    localparam int FMT_W      = 2;
    localparam int SLOT_W     = 4;
    localparam int ADDR_W     = 4;
    localparam int LINK_DEPTH = 2;
    localparam int OUT_DEPTH  = 4;

    localparam logic [DATA_W-1:0] MIX_C1  = 32'h85eb_ca6b;
    localparam logic [DATA_W-1:0] MIX_C2  = 32'hc2b2_ae35;
    localparam logic [DATA_W-1:0] MASK_LO = 32'h0000_ffff;

    typedef enum logic [FMT_W-1:0] {
        FMT_F32 = 2'd0,
        FMT_F16 = 2'd1,
        FMT_Q4  = 2'd2,
        FMT_Q8  = 2'd3
    } fmt_t;

    typedef enum logic [1:0] {
        REG_KEY    = 2'd0,
        REG_LAYER  = 2'd1,
        REG_FORMAT = 2'd2,
        REG_NONE   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_in;
        logic              last_in;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        logic              last_out;
    } out_item_t;

    typedef struct packed {
        logic [DATA_W-1:0]  key;
        logic [LAYER_W-1:0] layer_index;
        fmt_t               format;
    } cfg_t;

    // one classified element on its way to the mixer
    typedef struct packed {
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] data;
        logic              last;
        logic              half;
    } job_t;

    function automatic logic [DATA_W-1:0] fmix_pre(input logic [DATA_W-1:0] v);
        return v ^ (v >> 16);
    endfunction

    function automatic logic [DATA_W-1:0] fmix_mid(input logic [DATA_W-1:0] v);
        return v ^ (v >> 13);
    endfunction

    function automatic logic [DATA_W-1:0] fmix_post(input logic [DATA_W-1:0] v);
        return v ^ (v >> 16);
    endfunction

endpackage

// ----- design/hkwd_front.sv -----
// Front end: seed sequencer, counter bookkeeping and element classification.
module hkwd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  hkwd_pkg::cfg_t    cfg,
    input  logic              restart,
    input  logic              push,
    input  hkwd_pkg::in_item_t in_item,
    output logic              full,
    input  logic              link_full,
    output logic              job_push,
    output hkwd_pkg::job_t    job
);
    import hkwd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_ADD
    } state_t;

    state_t              state_reg, state_next;
    logic [DATA_W-1:0]   work_reg, work_next;
    logic [DATA_W-1:0]   offset_reg, offset_next;
    logic [DATA_W-1:0]   pos_reg, pos_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;

    logic                accept;
    logic [DATA_W-1:0]   term;
    logic [SLOT_W-1:0]   slot_m1;
    logic [SLOT_W-1:0]   words;
    logic                half;

    assign full     = restart || (state_reg != S_IDLE) || link_full;
    assign accept   = push && !full;
    assign job_push = accept;
    assign slot_m1  = slot_reg - 4'd1;
    assign words    = (cfg.format == FMT_Q4) ? 4'd4 : 4'd8;

    always_comb
    begin
        term = pos_reg;
        half = 1'b0;
        unique case (cfg.format) inside
            FMT_F32: half = 1'b0;
            FMT_F16: half = 1'b1;
            FMT_Q4, FMT_Q8:
            begin
                if (slot_reg == '0)
                begin
                    term = pos_reg << 1;
                    half = 1'b1;
                end
                else if (cfg.format == FMT_Q4)
                begin
                    term = (pos_reg << 3) + {{(DATA_W-SLOT_W){1'b0}}, slot_m1};
                end
                else
                begin
                    term = (pos_reg << 4) + {{(DATA_W-SLOT_W){1'b0}}, slot_m1};
                end
            end
            default: half = 1'b0;
        endcase
    end

    assign job.x    = term + offset_reg;
    assign job.data = in_item.data_in;
    assign job.last = in_item.last_in;
    assign job.half = half;

    always_comb
    begin
        state_next  = state_reg;
        work_next   = work_reg;
        offset_next = offset_reg;
        pos_next    = pos_reg;
        slot_next   = slot_reg;
        unique case (state_reg)
            S_IDLE: state_next = S_IDLE;
            S_MUL1:
            begin
                work_next  = fmix_mid(work_reg * MIX_C1);
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                work_next  = fmix_post(work_reg * MIX_C2);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                offset_next = work_reg + {{(DATA_W-LAYER_W){1'b0}}, cfg.layer_index};
                state_next  = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase

        if (accept)
        begin
            if (cfg.format == FMT_F32 || cfg.format == FMT_F16)
            begin
                pos_next = pos_reg + 32'd1;
            end
            else if (slot_reg >= words)
            begin
                slot_next = '0;
                pos_next  = pos_reg + 32'd1;
            end
            else
            begin
                slot_next = slot_reg + 4'd1;
            end
            if (in_item.last_in)
            begin
                pos_next  = '0;
                slot_next = '0;
            end
        end

        // a write in the middle of a rebuild starts the rebuild over
        if (restart)
        begin
            work_next  = fmix_pre(cfg.key ^ {{(DATA_W-LAYER_W){1'b0}}, cfg.layer_index});
            state_next = S_MUL1;
            pos_next   = '0;
            slot_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            work_reg   <= '0;
            offset_reg <= '0;
            pos_reg    <= '0;
            slot_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            work_reg   <= work_next;
            offset_reg <= offset_next;
            pos_reg    <= pos_next;
            slot_reg   <= slot_next;
        end
    end

    // no element slips in while the seed is being rebuilt
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !job_push)
        else $error("element accepted during seed update");

    // slot never runs past the block length in quantized formats
    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.format == FMT_Q4 || cfg.format == FMT_Q8) && $stable(cfg.format)
        && !$past(restart) |-> slot_reg <= words)
        else $error("slot out of block range");

endmodule

// ----- design/hkwd_link.sv -----
// Two-entry queue between front end and mixer.
module hkwd_link (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  hkwd_pkg::job_t wr_job,
    output logic           link_full,
    input  logic           rd,
    output logic           link_empty,
    output hkwd_pkg::job_t rd_job
);
    import hkwd_pkg::*;

    localparam int PTR_W = $clog2(LINK_DEPTH);
    localparam int CNT_W = $clog2(LINK_DEPTH + 1);

    job_t             mem [LINK_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr, do_rd;

    assign link_full  = (count_reg == CNT_W'(LINK_DEPTH));
    assign link_empty = (count_reg == '0);
    assign do_wr      = wr && !link_full;
    assign do_rd      = rd && !link_empty;
    assign rd_job     = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LINK_DEPTH))
        else $error("link queue overfilled");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("link count lost a transfer");

endmodule

// ----- design/hkwd_back.sv -----
// Back end: two-stage finalizer pipeline, keystream XOR and result queue.
module hkwd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                link_empty,
    input  hkwd_pkg::job_t      job,
    output logic                link_rd,
    output logic                empty,
    input  logic                pop,
    output hkwd_pkg::out_item_t out_item
);
    import hkwd_pkg::*;

    localparam int PTR_W = $clog2(OUT_DEPTH);
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);
    localparam int FLY_W = CNT_W + 1;

    logic              v1_reg, v2_reg;
    logic [DATA_W-1:0] a_reg, b_reg;
    logic [DATA_W-1:0] d1_reg, d2_reg;
    logic              l1_reg, l2_reg, h1_reg, h2_reg;

    out_item_t         mem [OUT_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [FLY_W-1:0]  in_flight;
    logic              do_pop;
    logic [DATA_W-1:0] mixed;
    out_item_t         wr_item;

    // every issued element has a reserved queue entry
    assign in_flight = FLY_W'(count_reg) + FLY_W'(v1_reg) + FLY_W'(v2_reg);
    assign link_rd   = !link_empty && (in_flight < FLY_W'(OUT_DEPTH));
    assign empty     = (count_reg == '0);
    assign do_pop    = pop && !empty;
    assign out_item  = mem[rd_ptr_reg];

    assign mixed            = fmix_post(b_reg) ^ d2_reg;
    assign wr_item.data_out = h2_reg ? (mixed & MASK_LO) : mixed;
    assign wr_item.last_out = l2_reg;

    always_ff @(posedge clk)
    begin
        a_reg  <= fmix_pre(job.x) * MIX_C1;
        d1_reg <= job.data;
        l1_reg <= job.last;
        h1_reg <= job.half;
        b_reg  <= fmix_mid(a_reg) * MIX_C2;
        d2_reg <= d1_reg;
        l2_reg <= l1_reg;
        h2_reg <= h1_reg;
        if (v2_reg)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            v1_reg <= link_rd;
            v2_reg <= v1_reg;
            if (v2_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (v2_reg && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !v2_reg)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        in_flight <= FLY_W'(OUT_DEPTH))
        else $error("more elements in flight than queue entries");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> count_reg < CNT_W'(OUT_DEPTH) || do_pop)
        else $error("result queue overrun");

    a_half_upper: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && h2_reg) |-> wr_item.data_out[DATA_W-1:16] == '0)
        else $error("halfword result has upper bits set");

endmodule

// ----- design/hash_keystream_weight_decrypt.sv -----
// Top level of the keystream weight decryptor: register port, front end, queue and mixer.
// A result passes through the link queue, the two finalizer stages and the result queue before it shows on out_item.
// Throughput: one element per cycle while full stays low, through the two registered multiplier stages.
// A write to a mapped register restarts counting and holds full high while the
// seed is rebuilt on the front end's own multiplier.
// Reset (rst_n, async low) clears registers, queues and counters; seed is zero.
module hash_keystream_weight_decrypt (
    input  logic                        clk,
    input  logic                        rst_n,
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hkwd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // element input queue side
    input  logic                        push,
    output logic                        full,
    input  hkwd_pkg::in_item_t          in_item,
    // result queue side
    output logic                        empty,
    input  logic                        pop,
    output hkwd_pkg::out_item_t         out_item
);
    import hkwd_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    logic      restart_reg, restart_next;
    logic      cfg_wr;
    reg_idx_t  idx;

    logic      link_full, link_empty, link_rd, job_push;
    job_t      job, rd_job;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    // register written on the access phase of a write transfer
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next     = cfg_reg;
        restart_next = 1'b0;
        if (cfg_wr)
        begin
            unique case (idx)
                REG_KEY:
                begin
                    cfg_next.key = pwdata;
                    restart_next = 1'b1;
                end
                REG_LAYER:
                begin
                    cfg_next.layer_index = pwdata[LAYER_W-1:0];
                    restart_next         = 1'b1;
                end
                REG_FORMAT:
                begin
                    cfg_next.format = fmt_t'(pwdata[FMT_W-1:0]);
                    restart_next    = 1'b1;
                end
                REG_NONE: restart_next = 1'b0;   // unmapped, ignored
                default:  restart_next = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_KEY:    prdata = cfg_reg.key;
            REG_LAYER:  prdata = {{(32-LAYER_W){1'b0}}, cfg_reg.layer_index};
            REG_FORMAT: prdata = {{(32-FMT_W){1'b0}}, cfg_reg.format};
            default:    prdata = '0;
        endcase
    end

    // restart fires the cycle after the write so the front end sees new values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg     <= '{key: '0, layer_index: '0, format: FMT_F32};
            restart_reg <= 1'b0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            restart_reg <= restart_next;
        end
    end

    hkwd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .restart   (restart_reg),
        .push      (push),
        .in_item   (in_item),
        .full      (full),
        .link_full (link_full),
        .job_push  (job_push),
        .job       (job)
    );

    hkwd_link u_link (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (job_push),
        .wr_job     (job),
        .link_full  (link_full),
        .rd         (link_rd),
        .link_empty (link_empty),
        .rd_job     (rd_job)
    );

    hkwd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .link_empty (link_empty),
        .job        (rd_job),
        .link_rd    (link_rd),
        .empty      (empty),
        .pop        (pop),
        .out_item   (out_item)
    );

    // a mapped register write restarts the seed, and input stays blocked during the restart
    a_restart_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        restart_reg |-> full)
        else $error("input open during restart");

    a_restart_follows_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && idx != REG_NONE) |=> restart_reg)
        else $error("register write did not restart");

    a_ignored_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && idx == REG_NONE) |=> $stable(cfg_reg))
        else $error("unmapped write changed a register");

endmodule
